// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the projected box size test.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define PBST_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pbst assertion failed");
// Checked on every clock edge, reset included.
`define PBST_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("pbst assertion failed");
`else
`define PBST_ASSERT(label, prop)
`define PBST_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== hw/rtl/pbst_pkg.sv =====
// Types, constants and register codes of the projected box size test.
package pbst_pkg;

   localparam int COORD_W   = 24;
   localparam int PT_W      = 26;
   localparam int ENTRY_W   = 16;
   localparam int PROD_W    = ENTRY_W + PT_W;
   localparam int DOT_W     = 44;
   localparam int DVD_W     = DOT_W + 16;
   localparam int DIV_RADIX = 4;
   localparam int DIV_STEPS = DVD_W / DIV_RADIX;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int PROJ_W    = 32;
   localparam int DIFF_W    = PROJ_W + 1;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int SUM_W     = SQ_W + 1;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int FIFO_DEPTH = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ROW0      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW3      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd4;

   // Matrix row selector codes used by the back end.
   localparam logic [1:0] ROW_X = 2'd0;
   localparam logic [1:0] ROW_Y = 2'd1;
   localparam logic [1:0] ROW_W = 2'd2;

   localparam logic [1:0] LAST_POINT = 2'd3;
   localparam logic [1:0] LAST_SQ    = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] min_z;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] max_y;
      logic signed [COORD_W-1:0] max_z;
   } box_type;

   typedef struct packed {
      logic        renderable;
      logic [31:0] max_diag_sq;
      logic        w_zero;
   } result_type;

   // Queue entry: the box plus the extruded z of the fourth point.
   typedef struct packed {
      box_type                box;
      logic signed [PT_W-1:0] far_z;
   } work_type;

   typedef struct packed {
      logic [63:0] row0;
      logic [63:0] row1;
      logic [63:0] row3;
      logic [31:0] threshold;
   } cfg_type;

   typedef struct packed {
      logic                    start;
      logic signed [DOT_W-1:0] num;
      logic signed [DOT_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [PROJ_W-1:0] quot;
   } div_rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_MUL, BK_ADD, BK_DIVGO, BK_DIV, BK_SQ, BK_ACC, BK_FIN
   } back_state_type;

endpackage

// ===== hw/rtl/projected_box_size_test.sv =====
// Top level of the projected box size test: registers, front, queue, back and divider.
//
//   channel  | handshake           | beat
//   ---------+---------------------+------------------------------------
//   request  | start / busy        | req_box: box min and max corners
//   response | rsp_strobe          | rsp_result: flag, size, zero-w flag
//   config   | csr_valid/csr_ready | csr_index, csr_data
//
// In the back end a box is taken from the queue, then per point three matrix rows are
// formed by a multiply and an add step each and two divisions run in the shared
// divider (load, 15 steps, result), then four squaring steps square and accumulate
// and the result is registered together with its strobe.
// Reset is synchronous and clears all control state and the configuration registers.
// The response strobe lasts one cycle; busy rises only when the queue is full.
`include "assert_macros.svh"
module projected_box_size_test
   import pbst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  box_type               req_box,
   output logic                  rsp_strobe,
   output result_type            rsp_result,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type     cfg_ff;
   logic        push;
   work_type    push_data;
   logic        pop;
   work_type    pop_data;
   logic        fifo_full;
   logic        fifo_empty;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign csr_ready = 1'b1;

   // Configuration registers; row 2 of the matrix has no effect and is not kept.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW0:      cfg_ff.row0      <= csr_data;
            CSR_ROW1:      cfg_ff.row1      <= csr_data;
            CSR_ROW2: begin
            end
            CSR_ROW3:      cfg_ff.row3      <= csr_data;
            CSR_THRESHOLD: cfg_ff.threshold <= csr_data[31:0];
            default: begin
            end
         endcase
      end
   end

   pbst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_box   (req_box),
      .busy      (busy),
      .fifo_full (fifo_full),
      .push      (push),
      .push_data (push_data)
   );

   pbst_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   pbst_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   pbst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .fifo_empty (fifo_empty),
      .fifo_data  (pop_data),
      .pop        (pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_strobe (rsp_strobe),
      .rsp_result (rsp_result)
   );

   // Result strobes never come back to back.
   `PBST_ASSERT(a_strobe_gap, rsp_strobe |=> !rsp_strobe)
   // A zero w forces the saturated size and a failed test.
   `PBST_ASSERT(a_wzero_result, (rsp_strobe && rsp_result.w_zero) |-> (rsp_result.max_diag_sq == 32'hFFFF_FFFF && !rsp_result.renderable))
   // No result follows directly after reset.
   `PBST_ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> !rsp_strobe)

endmodule

// ===== hw/rtl/pbst_fifo.sv =====
// Two-entry queue between the front and the back of the projected box size test.
module pbst_fifo
   import pbst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   input  logic     pop,
   output work_type pop_data,
   output logic     full,
   output logic     empty
);

   work_type   mem_ff [FIFO_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'(FIFO_DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/pbst_front.sv =====
// Front end: accepts boxes, forms the extruded z and feeds the queue.
module pbst_front
   import pbst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  box_type  req_box,
   output logic     busy,
   input  logic     fifo_full,
   output logic     push,
   output work_type push_data
);

   logic     hold_valid_ff, hold_valid_in;
   work_type hold_ff;
   logic     accept;

   // A held beat leaves when the queue has room; a new one may enter the same cycle.
   assign busy      = hold_valid_ff && fifo_full;
   assign accept    = start && !busy;
   assign push      = hold_valid_ff && !fifo_full;
   assign push_data = hold_ff;

   always_comb begin
      hold_valid_in = accept || (hold_valid_ff && !push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   // Far point z is twice max z minus min z.
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff.box   <= req_box;
         hold_ff.far_z <= (PT_W'(req_box.max_z) <<< 1) - PT_W'(req_box.min_z);
      end
   end

endmodule

// ===== hw/rtl/pbst_divider.sv =====
// Iterative signed divider giving (num * 2^16) / den, saturated to signed Q16.16.
module pbst_divider
   import pbst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 run_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DOT_W-1:0]     rem_ff, rem_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DOT_W-1:0]     den_ff;
   logic                 neg_ff;

   // Several restoring steps per cycle; the dividend shifts out as quotient bits shift in.
   always_comb begin
      logic [DOT_W:0] trial;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int j = 0; j < DIV_RADIX; j++) begin
         trial  = {rem_in, quo_in[DVD_W-1]};
         quo_in = {quo_in[DVD_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial     = trial - {1'b0, den_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[DOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand load with magnitudes, then iteration.
   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         quo_ff <= {(req.num < 0) ? DOT_W'(-req.num) : DOT_W'(req.num), 16'd0};
         den_ff <= (req.den < 0) ? DOT_W'(-req.den) : DOT_W'(req.den);
         neg_ff <= (req.num < 0) != (req.den < 0);
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // Sign and saturation.
   always_comb begin
      rsp.done = done_ff;
      if (neg_ff) begin
         if (quo_ff > DVD_W'(64'h8000_0000)) begin
            rsp.quot = 32'sh8000_0000;
         end else begin
            rsp.quot = PROJ_W'(-quo_ff[PROJ_W:0]);
         end
      end else begin
         if (quo_ff > DVD_W'(64'h7FFF_FFFF)) begin
            rsp.quot = 32'sh7FFF_FFFF;
         end else begin
            rsp.quot = PROJ_W'(quo_ff[PROJ_W-1:0]);
         end
      end
   end

endmodule

// ===== hw/rtl/pbst_back.sv =====
// Back end: projects the four points, squares the diagonals and issues the result.
module pbst_back
   import pbst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        fifo_empty,
   input  work_type    fifo_data,
   output logic        pop,
   output div_req_type div_req,
   input  div_rsp_type div_rsp,
   output logic        rsp_strobe,
   output result_type  rsp_result
);

   back_state_type state_ff, state_in;

   work_type                 item_ff;
   logic [1:0]               pt_ff;
   logic [1:0]               row_ff;
   logic [1:0]               sq_ff;
   logic                     divy_ff;
   logic                     wz_ff;
   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [DOT_W-1:0]  dot_x_ff, dot_y_ff, dot_w_ff;
   logic signed [PROJ_W-1:0] px_ff [4];
   logic signed [PROJ_W-1:0] py_ff [4];
   logic [SQ_W-1:0]          sqp_ff;
   logic [SUM_W-1:0]         sum0_ff, sum1_ff;
   logic                     strobe_ff;
   result_type               result_ff;

   logic [63:0]              row_sel;
   logic signed [PT_W-1:0]   coord [3];
   logic signed [DOT_W-1:0]  dot_sum;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        mag;
   logic [31:0]              d0, d1, dm;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (!fifo_empty) state_in = BK_MUL;
         BK_MUL:   state_in = BK_ADD;
         BK_ADD:   state_in = (row_ff == ROW_W) ? BK_DIVGO : BK_MUL;
         BK_DIVGO: state_in = BK_DIV;
         BK_DIV: begin
            if (div_rsp.done) begin
               if (!divy_ff) state_in = BK_DIVGO;
               else if (pt_ff == LAST_POINT) state_in = BK_SQ;
               else state_in = BK_MUL;
            end
         end
         BK_SQ:    state_in = BK_ACC;
         BK_ACC:   state_in = (sq_ff == LAST_SQ) ? BK_FIN : BK_SQ;
         BK_FIN:   state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      pop           = (state_ff == BK_IDLE) && !fifo_empty;
      div_req.start = (state_ff == BK_DIVGO);
      div_req.num   = divy_ff ? dot_y_ff : dot_x_ff;
      div_req.den   = dot_w_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == BK_FIN);
      end
   end

   // Point coordinates and matrix row for the current step.
   always_comb begin
      coord[0] = PT_W'((pt_ff == 2'd0) ? item_ff.box.min_x : item_ff.box.max_x);
      coord[1] = PT_W'((pt_ff == 2'd0) ? item_ff.box.min_y : item_ff.box.max_y);
      case (pt_ff)
         2'd1:    coord[2] = PT_W'(item_ff.box.max_z);
         2'd3:    coord[2] = item_ff.far_z;
         default: coord[2] = PT_W'(item_ff.box.min_z);
      endcase
      case (row_ff)
         ROW_X:   row_sel = cfg.row0;
         ROW_Y:   row_sel = cfg.row1;
         default: row_sel = cfg.row3;
      endcase
      // Homogeneous coordinate is one in Q16.8, so the last column is a shift.
      dot_sum = DOT_W'(prod_ff[0]) + DOT_W'(prod_ff[1]) + DOT_W'(prod_ff[2])
              + (DOT_W'($signed(row_sel[63:48])) <<< 8);
   end

   // Diagonal component for the current squaring step.
   always_comb begin
      case (sq_ff)
         2'd0:    diff = DIFF_W'(px_ff[1]) - DIFF_W'(px_ff[0]);
         2'd1:    diff = DIFF_W'(py_ff[1]) - DIFF_W'(py_ff[0]);
         2'd2:    diff = DIFF_W'(px_ff[3]) - DIFF_W'(px_ff[2]);
         default: diff = DIFF_W'(py_ff[3]) - DIFF_W'(py_ff[2]);
      endcase
      mag = (diff < 0) ? DIFF_W'(-diff) : DIFF_W'(diff);
      d0  = (|sum0_ff[SUM_W-1:48]) ? 32'hFFFF_FFFF : sum0_ff[47:16];
      d1  = (|sum1_ff[SUM_W-1:48]) ? 32'hFFFF_FFFF : sum1_ff[47:16];
      dm  = (d0 > d1) ? d0 : d1;
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            item_ff <= fifo_data;
            pt_ff   <= 2'd0;
            row_ff  <= ROW_X;
            sq_ff   <= 2'd0;
            divy_ff <= 1'b0;
            wz_ff   <= 1'b0;
            sum0_ff <= '0;
            sum1_ff <= '0;
         end
         BK_MUL: begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[c] <= $signed(row_sel[16*c +: ENTRY_W]) * coord[c];
            end
         end
         BK_ADD: begin
            case (row_ff)
               ROW_X:   dot_x_ff <= dot_sum;
               ROW_Y:   dot_y_ff <= dot_sum;
               default: dot_w_ff <= dot_sum;
            endcase
            row_ff  <= (row_ff == ROW_W) ? ROW_X : row_ff + 2'd1;
            divy_ff <= 1'b0;
         end
         BK_DIVGO: begin
         end
         BK_DIV: begin
            if (div_rsp.done) begin
               if (!divy_ff) begin
                  px_ff[pt_ff] <= div_rsp.quot;
                  divy_ff      <= 1'b1;
               end else begin
                  py_ff[pt_ff] <= div_rsp.quot;
                  wz_ff        <= wz_ff || (dot_w_ff == '0);
                  pt_ff        <= pt_ff + 2'd1;
               end
            end
         end
         BK_SQ: begin
            sqp_ff <= SQ_W'(mag) * SQ_W'(mag);
         end
         BK_ACC: begin
            if (sq_ff[1]) sum1_ff <= sum1_ff + SUM_W'(sqp_ff);
            else sum0_ff <= sum0_ff + SUM_W'(sqp_ff);
            sq_ff <= sq_ff + 2'd1;
         end
         BK_FIN: begin
            result_ff.w_zero      <= wz_ff;
            result_ff.max_diag_sq <= wz_ff ? 32'hFFFF_FFFF : dm;
            result_ff.renderable  <= !wz_ff && (dm < cfg.threshold);
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_result = result_ff;

endmodule
